// File: hw/rtl/qalu_pkg.sv
package qalu_pkg;

  // Component format and derived widths.
  localparam int CW  = 16;
  localparam int FB  = 12;
  localparam int PW  = 2 * CW;
  localparam int HW  = 2 * CW + 2;
  localparam int SW  = 2 * CW + 1;
  localparam int RW  = CW + 1;
  localparam int NS  = RW;
  localparam int SPW = 2 * RW;
  localparam int RMW = RW + 3;
  localparam int DW  = CW + 2 * FB + 1;
  localparam int XW  = (DW > SW + CW + 1) ? DW : SW + CW + 1;
  localparam int IW  = 9 * CW;
  localparam int OW  = 4 * CW;

  typedef logic signed [CW-1:0] comp_t;

  localparam comp_t CMAX = {1'b0, {(CW - 1){1'b1}}};
  localparam comp_t CMIN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CW-1:0] UMAX  = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] UHALF = {1'b1, {(CW - 1){1'b0}}};
  localparam logic signed [HW-1:0] HALF_H = HW'(1) << (FB - 1);
  localparam logic [SW-1:0] HALF_S = SW'(1) << (FB - 1);

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_SCALE = 3'd3,
    OP_NORM2 = 3'd4,
    OP_NORM  = 3'd5,
    OP_CONJ  = 3'd6,
    OP_INV   = 3'd7
  } op_t;

  // A clamped component with its saturation mark.
  typedef struct packed {
    logic  sat;
    comp_t val;
  } cres_t;

  // Everything an item carries through the square root and divide stages.
  typedef struct packed {
    op_t                  mode;
    comp_t [3:0]          r;
    logic                 dsat;
    logic                 zero;
    logic [3:0]           neg;
    logic [3:0]           ovf;
    logic [SW-1:0]        s;
    logic [RW-1:0]        root;
    logic [RMW-1:0]       srem;
    logic [3:0][XW-1:0]   drem;
    logic [3:0][RW-1:0]   q;
  } it_t;

  // Clamp a slightly wider signed value to the component range.
  function automatic cres_t clamp_w(input logic signed [CW+1:0] v);
    cres_t c;
    if (v > CMAX) begin
      c.sat = 1'b1;
      c.val = CMAX;
    end else if (v < CMIN) begin
      c.sat = 1'b1;
      c.val = CMIN;
    end else begin
      c.sat = 1'b0;
      c.val = v[CW-1:0];
    end
    return c;
  endfunction

  // Drop the fraction bits, rounding to nearest with ties upward, then clamp.
  function automatic cres_t round_clamp(input logic signed [HW-1:0] v);
    logic signed [HW-1:0] t;
    cres_t c;
    t = v + HALF_H;
    t = t >>> FB;
    if (t > CMAX) begin
      c.sat = 1'b1;
      c.val = CMAX;
    end else if (t < CMIN) begin
      c.sat = 1'b1;
      c.val = CMIN;
    end else begin
      c.sat = 1'b0;
      c.val = t[CW-1:0];
    end
    return c;
  endfunction

  // Sign extend a product to the width of a four term sum.
  function automatic logic signed [HW-1:0] sx_p(input logic signed [PW-1:0] p);
    return {{(HW - PW){p[PW-1]}}, p};
  endfunction

endpackage

// File: hw/rtl/quaternion_alu_unit.sv
// Quaternion arithmetic unit, signed fixed point, one result word per input word.
// Pipeline: four front stages, one square root and divide stage per root bit, and
// one output stage lie between input acceptance and result valid.
// Throughput: one word per cycle; the whole pipeline advances together and holds
// while a result waits. Reset (rst, synchronous, active high) clears all valid bits.
module quaternion_alu_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // a_s, a_v1, a_v2, a_v3, b_s, b_v1, b_v2, b_v3, factor from the lowest bit up
  input  logic [qalu_pkg::IW-1:0] s_tdata,
  // mode
  input  logic [2:0]              s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // r_s, r_v1, r_v2, r_v3 from the lowest bit up
  output logic [qalu_pkg::OW-1:0] m_tdata,
  // saturated, zero_norm from the lowest bit up
  output logic [1:0]              m_tuser
);

  logic          en;
  logic          f_vld;
  qalu_pkg::it_t f_it;
  logic          i_vld;
  qalu_pkg::it_t i_it;

  // The pipeline moves whenever the output register is empty or being read.
  assign en       = m_tready || !m_tvalid;
  assign s_tready = en;

  qalu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_tvalid),
    .in_mode (qalu_pkg::op_t'(s_tuser)),
    .in_data (s_tdata),
    .out_vld (f_vld),
    .out_it  (f_it)
  );

  qalu_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .in_it   (f_it),
    .out_vld (i_vld),
    .out_it  (i_it)
  );

  qalu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (i_vld),
    .in_it    (i_it),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: hw/rtl/qalu_front.sv
module qalu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  qalu_pkg::op_t   in_mode,
  input  logic [qalu_pkg::IW-1:0] in_data,
  output logic            out_vld,
  output qalu_pkg::it_t   out_it
);

  // Stage A: operand registers.
  logic                  a_vld;
  qalu_pkg::op_t         a_mode;
  qalu_pkg::comp_t       a_q [4];
  qalu_pkg::comp_t       b_q [4];
  qalu_pkg::comp_t       a_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mode <= in_mode;
      for (int i = 0; i < 4; i++) begin
        a_q[i] <= in_data[i*qalu_pkg::CW +: qalu_pkg::CW];
        b_q[i] <= in_data[(4+i)*qalu_pkg::CW +: qalu_pkg::CW];
      end
      a_f <= in_data[8*qalu_pkg::CW +: qalu_pkg::CW];
    end
  end

  // Stage B: all products, plus the operations that need no multiplier.
  logic                          b_vld;
  qalu_pkg::op_t                 b_mode;
  logic signed [qalu_pkg::PW-1:0] b_p  [4][4];
  logic signed [qalu_pkg::PW-1:0] b_sc [4];
  logic signed [qalu_pkg::PW-1:0] b_sq [4];
  qalu_pkg::cres_t               b_dir [4];
  logic [qalu_pkg::CW-1:0]       b_mag [4];
  logic [3:0]                    b_neg;

  qalu_pkg::cres_t               dir_c [4];
  logic [qalu_pkg::CW-1:0]       mag_c [4];
  logic [3:0]                    neg_c;

  always_comb begin
    logic signed [qalu_pkg::CW+1:0] ea;
    logic signed [qalu_pkg::CW+1:0] eb;
    logic signed [qalu_pkg::CW+1:0] na;
    for (int i = 0; i < 4; i++) begin
      ea = a_q[i];
      eb = b_q[i];
      na = -ea;
      mag_c[i] = (a_q[i] < 0) ? na[qalu_pkg::CW-1:0] : a_q[i];
      neg_c[i] = (i == 0) ? (a_q[i] < 0) : (a_q[i] > 0);
      case (a_mode)
        qalu_pkg::OP_ADD: begin
          dir_c[i] = qalu_pkg::clamp_w(ea + eb);
        end
        qalu_pkg::OP_SUB: begin
          dir_c[i] = qalu_pkg::clamp_w(ea - eb);
        end
        qalu_pkg::OP_CONJ: begin
          if (i == 0) begin
            dir_c[i] = {1'b0, a_q[i]};
          end else begin
            dir_c[i] = qalu_pkg::clamp_w(na);
          end
        end
        default: begin
          dir_c[i] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mode <= a_mode;
      b_neg  <= neg_c;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          b_p[i][j] <= a_q[i] * b_q[j];
        end
        b_sc[i]  <= a_q[i] * a_f;
        b_sq[i]  <= a_q[i] * a_q[i];
        b_dir[i] <= dir_c[i];
        b_mag[i] <= mag_c[i];
      end
    end
  end

  // Stage C: Hamilton sums and the sum of squares.
  logic                          c_vld;
  qalu_pkg::op_t                 c_mode;
  logic signed [qalu_pkg::HW-1:0] c_v [4];
  logic [qalu_pkg::SW-1:0]       c_s;
  qalu_pkg::cres_t               c_dir [4];
  logic [qalu_pkg::CW-1:0]       c_mag [4];
  logic [3:0]                    c_neg;

  logic signed [qalu_pkg::HW-1:0] v_c [4];
  logic signed [qalu_pkg::HW-1:0] h_c [4];

  always_comb begin
    h_c[0] = qalu_pkg::sx_p(b_p[0][0]) - qalu_pkg::sx_p(b_p[1][1])
           - qalu_pkg::sx_p(b_p[2][2]) - qalu_pkg::sx_p(b_p[3][3]);
    h_c[1] = qalu_pkg::sx_p(b_p[0][1]) + qalu_pkg::sx_p(b_p[1][0])
           + qalu_pkg::sx_p(b_p[2][3]) - qalu_pkg::sx_p(b_p[3][2]);
    h_c[2] = qalu_pkg::sx_p(b_p[0][2]) - qalu_pkg::sx_p(b_p[1][3])
           + qalu_pkg::sx_p(b_p[2][0]) + qalu_pkg::sx_p(b_p[3][1]);
    h_c[3] = qalu_pkg::sx_p(b_p[0][3]) + qalu_pkg::sx_p(b_p[1][2])
           - qalu_pkg::sx_p(b_p[2][1]) + qalu_pkg::sx_p(b_p[3][0]);
    for (int i = 0; i < 4; i++) begin
      case (b_mode)
        qalu_pkg::OP_MUL:   v_c[i] = h_c[i];
        qalu_pkg::OP_SCALE: v_c[i] = qalu_pkg::sx_p(b_sc[i]);
        default:            v_c[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mode <= b_mode;
      c_neg  <= b_neg;
      c_s    <= {1'b0, b_sq[0]} + {1'b0, b_sq[1]} + {1'b0, b_sq[2]} + {1'b0, b_sq[3]};
      for (int i = 0; i < 4; i++) begin
        c_v[i]   <= v_c[i];
        c_dir[i] <= b_dir[i];
        c_mag[i] <= b_mag[i];
      end
    end
  end

  // Stage D: rounding, squared norm, divide range check and iteration setup.
  qalu_pkg::it_t d_next;

  always_comb begin
    logic [qalu_pkg::SW-1:0] nv;
    logic [qalu_pkg::XW-1:0] dd;
    logic [qalu_pkg::XW-1:0] dlim;
    qalu_pkg::cres_t         rc;
    d_next      = '0;
    rc          = '0;
    d_next.mode = c_mode;
    d_next.s    = c_s;
    d_next.neg  = c_neg;
    d_next.zero = (c_s == '0);
    nv   = (c_s + qalu_pkg::HALF_S) >> qalu_pkg::FB;
    dlim = qalu_pkg::XW'(c_s) << (qalu_pkg::CW + 1);
    for (int i = 0; i < 4; i++) begin
      dd = qalu_pkg::XW'(c_mag[i]) << (2 * qalu_pkg::FB + 1);
      d_next.drem[i] = dd;
      d_next.ovf[i]  = (dd >= dlim);
    end
    case (c_mode)
      qalu_pkg::OP_MUL, qalu_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          rc = qalu_pkg::round_clamp(c_v[i]);
          d_next.r[i] = rc.val;
          d_next.dsat = d_next.dsat | rc.sat;
        end
      end
      qalu_pkg::OP_NORM2: begin
        if (nv > qalu_pkg::UMAX) begin
          d_next.r[0] = qalu_pkg::CMAX;
          d_next.dsat = 1'b1;
        end else begin
          d_next.r[0] = nv[qalu_pkg::CW-1:0];
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          d_next.r[i] = c_dir[i].val;
          d_next.dsat = d_next.dsat | c_dir[i].sat;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_it <= d_next;
    end
  end

endmodule

// File: hw/rtl/qalu_iter.sv
module qalu_iter (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  qalu_pkg::it_t in_it,
  output logic          out_vld,
  output qalu_pkg::it_t out_it
);

  // One square root digit and one quotient bit per lane in every stage.
  qalu_pkg::it_t st  [qalu_pkg::NS];
  logic          vld [qalu_pkg::NS];

  for (genvar t = 0; t < qalu_pkg::NS; t++) begin : g_step
    localparam int K = qalu_pkg::CW - t;

    qalu_pkg::it_t cur;
    qalu_pkg::it_t nx;
    logic          cur_vld;

    if (t == 0) begin : g_first
      assign cur     = in_it;
      assign cur_vld = in_vld;
    end else begin : g_next
      assign cur     = st[t-1];
      assign cur_vld = vld[t-1];
    end

    always_comb begin
      logic [qalu_pkg::SPW-1:0] sp;
      logic [qalu_pkg::RMW-1:0] rs;
      logic [qalu_pkg::RMW-1:0] tr;
      logic [qalu_pkg::XW-1:0]  dv;
      nx = cur;
      // Square root: bring down two bits and try the next root bit.
      sp = qalu_pkg::SPW'(cur.s);
      rs = {cur.srem[qalu_pkg::RMW-3:0], sp[qalu_pkg::SPW-1-2*t -: 2]};
      tr = qalu_pkg::RMW'({cur.root, 2'b01});
      if (rs >= tr) begin
        nx.srem = rs - tr;
        nx.root = {cur.root[qalu_pkg::RW-2:0], 1'b1};
      end else begin
        nx.srem = rs;
        nx.root = {cur.root[qalu_pkg::RW-2:0], 1'b0};
      end
      // Restoring divide by the sum of squares, one quotient bit per lane.
      dv = qalu_pkg::XW'(cur.s) << K;
      for (int i = 0; i < 4; i++) begin
        if (cur.drem[i] >= dv) begin
          nx.drem[i]  = cur.drem[i] - dv;
          nx.q[i][K]  = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[t] <= 1'b0;
      end else if (en) begin
        vld[t] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[t] <= nx;
      end
    end
  end

  assign out_vld = vld[qalu_pkg::NS-1];
  assign out_it  = st[qalu_pkg::NS-1];

endmodule

// File: hw/rtl/qalu_back.sv
module qalu_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  qalu_pkg::it_t           in_it,
  output logic                    m_tvalid,
  output logic [qalu_pkg::OW-1:0] m_tdata,
  output logic [1:0]              m_tuser
);

  qalu_pkg::comp_t r_c [4];
  logic            sat_c;
  logic            zn_c;

  // Final rounding of the root and the quotients, then result selection.
  always_comb begin
    logic [qalu_pkg::RW:0]   v;
    logic [qalu_pkg::RW:0]   qr;
    logic [qalu_pkg::CW-1:0] qm;
    logic                    big;
    v = qalu_pkg::RW'(in_it.root) + (qalu_pkg::RW + 1)'(
          in_it.srem > qalu_pkg::RMW'(in_it.root));
    qr    = '0;
    qm    = '0;
    big   = 1'b0;
    sat_c = 1'b0;
    zn_c  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      r_c[i] = '0;
    end
    case (in_it.mode)
      qalu_pkg::OP_NORM: begin
        if (v > qalu_pkg::UMAX) begin
          r_c[0] = qalu_pkg::CMAX;
          sat_c  = 1'b1;
        end else begin
          r_c[0] = v[qalu_pkg::CW-1:0];
        end
      end
      qalu_pkg::OP_INV: begin
        if (in_it.zero) begin
          zn_c = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            qr  = ((qalu_pkg::RW + 1)'(in_it.q[i]) + 1'b1) >> 1;
            qm  = qr[qalu_pkg::CW-1:0];
            big = in_it.neg[i] ? (qr > qalu_pkg::UHALF) : (qr > qalu_pkg::UMAX);
            if (in_it.ovf[i] || big) begin
              r_c[i] = in_it.neg[i] ? qalu_pkg::CMIN : qalu_pkg::CMAX;
              sat_c  = 1'b1;
            end else begin
              r_c[i] = in_it.neg[i] ? -qm : qm;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          r_c[i] = in_it.r[i];
        end
        sat_c = in_it.dsat;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {r_c[3], r_c[2], r_c[1], r_c[0]};
      m_tuser <= {zn_c, sat_c};
    end
  end

endmodule

// File: hw/rtl/qalu_check.sv
module qalu_check (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_tready,
  input logic                    m_tvalid,
  input logic                    m_tready,
  input logic [qalu_pkg::OW-1:0] m_tdata,
  input logic [1:0]              m_tuser
);

  // A zero norm inverse never reports saturation.
  a_zn_nosat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("zero_norm with saturated set");

  // A zero norm inverse returns the zero quaternion.
  a_zn_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == '0)
    else $error("zero_norm with nonzero result");

  // The input side is open exactly when the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (m_tready || !m_tvalid))
    else $error("input ready does not follow output state");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind quaternion_alu_unit qalu_check u_qalu_check (.*);

// File: test/quaternion_alu_unit_tb.sv
module quaternion_alu_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [15:0] q_t;

  typedef struct packed {
    q_t r3;
    q_t r2;
    q_t r1;
    q_t r0;
    logic zn;
    logic sat;
  } answer_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [qalu_pkg::IW-1:0] s_tdata;
  logic [2:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [qalu_pkg::OW-1:0] m_tdata;
  logic [1:0] m_tuser;

  answer_t expected_answers[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;

  quaternion_alu_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Clamp a wide value to the component range.
  function automatic longint clamp16(input longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // Divide by 2^12, rounding to nearest with ties upward (floor after adding half).
  function automatic longint round_q12(input longint v);
    return (v + 2048) >>> 12;
  endfunction

  // Rounded integer square root.
  function automatic longint unsigned root_round(input longint unsigned s);
    longint unsigned r;
    longint unsigned bitv;
    longint unsigned rem;
    r = 0;
    bitv = 64'd1 << 62;
    rem = s;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return (rem > r) ? r + 1 : r;
  endfunction

  // Magnitude times 2^24 over the sum of squares, ties away from zero, capped at 2^40.
  function automatic longint unsigned inv_quot(input longint unsigned m,
                                               input longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    longint unsigned cap;
    cap = 64'd1 << 40;
    q = m / d;
    rem = m % d;
    for (int i = 0; i < 24; i++) begin
      if (q > cap) q = cap;
      q <<= 1;
      if (rem >= d - rem) begin
        rem = rem - (d - rem);
        q |= 1;
      end else begin
        rem <<= 1;
      end
    end
    if (rem >= d - rem) q++;
    return (q > cap) ? cap : q;
  endfunction

  // Predict the result word of one quaternion operation.
  function automatic answer_t quat_result(input qalu_pkg::op_t op, input longint a[4],
                                          input longint b[4], input longint f);
    longint r[4];
    longint unsigned s;
    longint unsigned v;
    longint unsigned q;
    logic sat;
    logic zn;
    answer_t ans;
    sat = 1'b0;
    zn = 1'b0;
    r = '{0, 0, 0, 0};
    s = 0;
    for (int i = 0; i < 4; i++) s += a[i] * a[i];
    case (op)
      qalu_pkg::OP_ADD: begin
        for (int i = 0; i < 4; i++) r[i] = clamp16(a[i] + b[i], sat);
      end
      qalu_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) r[i] = clamp16(a[i] - b[i], sat);
      end
      qalu_pkg::OP_MUL: begin
        r[0] = clamp16(round_q12(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]), sat);
        r[1] = clamp16(round_q12(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]), sat);
        r[2] = clamp16(round_q12(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]), sat);
        r[3] = clamp16(round_q12(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]), sat);
      end
      qalu_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) r[i] = clamp16(round_q12(a[i] * f), sat);
      end
      qalu_pkg::OP_NORM2: begin
        v = (s >> 12) + ((s >> 11) & 1);
        r[0] = clamp16(longint'(v), sat);
      end
      qalu_pkg::OP_NORM: begin
        v = root_round(s);
        r[0] = clamp16(longint'(v), sat);
      end
      qalu_pkg::OP_CONJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = clamp16(-a[i], sat);
      end
      default: begin
        if (s == 0) begin
          zn = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            q = inv_quot(longint'(a[i] < 0 ? -a[i] : a[i]), s);
            if ((i == 0) ? (a[i] < 0) : (a[i] > 0)) r[i] = clamp16(-longint'(q), sat);
            else r[i] = clamp16(longint'(q), sat);
          end
        end
      end
    endcase
    ans.r0 = r[0][15:0];
    ans.r1 = r[1][15:0];
    ans.r2 = r[2][15:0];
    ans.r3 = r[3][15:0];
    ans.sat = sat;
    ans.zn = zn;
    return ans;
  endfunction

  // Send one word, holding valid until it is accepted.
  task automatic send_word(input qalu_pkg::op_t op, input q_t av[4], input q_t bv[4],
                           input q_t f);
    longint a[4];
    longint b[4];
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 4; i++) begin
      a[i] = av[i];
      b[i] = bv[i];
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {f, bv[3], bv[2], bv[1], bv[0], av[3], av[2], av[1], av[0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_answers.push_back(quat_result(op, a, b, longint'(f)));
  endtask

  // Random component, biased toward the extremes and small magnitudes.
  function automatic q_t rand_comp();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return q_t'($urandom_range(8192)) - 16'sd4096;
      3: return 16'sd0;
      default: return q_t'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    q_t z[4];
    q_t mx[4];
    q_t mn[4];
    q_t one[4];
    q_t mix[4];
    z = '{0, 0, 0, 0};
    mx = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    mn = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000};
    one = '{16'sd4096, 0, 0, 0};
    mix = '{16'sd4096, -16'sd2048, 16'sd1, -16'sd8000};
    for (int op = 0; op < 8; op++) begin
      send_word(qalu_pkg::op_t'(op), mx, mx, 16'sh7fff);
      send_word(qalu_pkg::op_t'(op), mn, mx, -16'sh8000);
      send_word(qalu_pkg::op_t'(op), mix, one, 16'sd2048);
    end
    // Inverse of the zero quaternion raises zero_norm.
    send_word(qalu_pkg::OP_INV, z, mx, 16'sd0);
  endtask

  task automatic test_random(input int count);
    q_t a[4];
    q_t b[4];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 4; i++) begin
        a[i] = rand_comp();
        b[i] = rand_comp();
      end
      send_word(qalu_pkg::op_t'($urandom_range(7)), a, b, rand_comp());
    end
  endtask

  // Hold off until every outstanding result has drained.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[63:48], m_tdata[47:32], m_tdata[31:16], m_tdata[15:0],
             m_tuser[1], m_tuser[0]};
      if (expected_answers.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        if (got.r0 !== want.r0) begin
          $error("r_s expected %0d actual %0d", want.r0, got.r0);
          errors++;
        end
        if (got.r1 !== want.r1) begin
          $error("r_v1 expected %0d actual %0d", want.r1, got.r1);
          errors++;
        end
        if (got.r2 !== want.r2) begin
          $error("r_v2 expected %0d actual %0d", want.r2, got.r2);
          errors++;
        end
        if (got.r3 !== want.r3) begin
          $error("r_v3 expected %0d actual %0d", want.r3, got.r3);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $error("saturated expected %0d actual %0d", want.sat, got.sat);
          errors++;
        end
        if (got.zn !== want.zn) begin
          $error("zero_norm expected %0d actual %0d", want.zn, got.zn);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    errors = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 67;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    drain();
    send_idle_pct = 67;
    recv_idle_pct = 18;
    test_random(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(300);
    s_tvalid <= 1'b0;
    waited = 0;
    while (expected_answers.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("quaternion_alu_unit verification clean");
    end else begin
      $display("quaternion_alu_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("quaternion_alu_unit verification failed");
    $finish;
  end

endmodule
